// File: rtl/pbp_pkg.sv
// ----------------------------------------------------------------------------
// pbp_pkg
// Types, widths and codes shared by the proportional block partitioner.
// ----------------------------------------------------------------------------
package pbp_pkg;

   localparam int SHARE_W      = 17;
   localparam int SIZE_W       = 31;
   localparam int ACTIVE_W     = 5;
   localparam int PROC_INDEX_W = 4;
   localparam int WORD_W       = 32;
   localparam int LEFT_W       = 33;
   localparam int PROD_W       = SIZE_W + SHARE_W;
   localparam int FRAC_W       = 16;
   localparam int ROUND_BIAS   = 32768;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 32;
   localparam int DIV_COUNT_W  = 5;

   typedef logic [SHARE_W-1:0]         share_type;
   typedef logic [SIZE_W-1:0]          size_type;
   typedef logic [ACTIVE_W-1:0]        active_type;
   typedef logic [PROC_INDEX_W-1:0]    proc_index_type;
   typedef logic [WORD_W-1:0]          word_type;
   typedef logic signed [WORD_W-1:0]   elem_type;
   typedef logic [LEFT_W-1:0]          left_type;
   typedef logic [PROD_W-1:0]          prod_type;
   typedef logic [CSR_ADDR_W-1:0]      csr_addr_type;
   typedef logic [CSR_DATA_W-1:0]      csr_data_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TOTAL_SIZE   = 2'd0,
      CSR_GRANULE      = 2'd1,
      CSR_ACTIVE_PROCS = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_ROUND,
      ST_COMMIT,
      ST_ADJUST,
      ST_READ,
      ST_LOAD,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic load_share;
      logic mult;
      logic round;
      logic commit;
      logic adjust;
      logic read;
      logic load;
      logic advance;
      logic clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic burst_due;
      logic last_item;
      logic rsp_taken;
   } ctrl_status_type;

endpackage

// File: rtl/pbp_if.sv
// ----------------------------------------------------------------------------
// pbp channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pbp_req_if;
   logic               valid;
   logic               ready;
   pbp_pkg::share_type share;

   modport source (output valid, output share, input ready);
   modport sink   (input valid, input share, output ready);
endinterface

interface pbp_rsp_if;
   logic                    valid;
   logic                    ready;
   pbp_pkg::proc_index_type proc_index;
   pbp_pkg::elem_type       elem_count;
   pbp_pkg::elem_type       offset;
   logic                    last;

   modport source (output valid, output proc_index, output elem_count, output offset,
                   output last, input ready);
   modport sink   (input valid, input proc_index, input elem_count, input offset,
                   input last, output ready);
endinterface

interface pbp_csr_if;
   logic                  valid;
   logic                  ready;
   pbp_pkg::csr_addr_type index;
   pbp_pkg::csr_data_type data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/pbp_divider.sv
// ----------------------------------------------------------------------------
// pbp_divider
// Restoring divider, one quotient bit a cycle, gives total_size / granule.
// ----------------------------------------------------------------------------
module pbp_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pbp_pkg::size_type dividend,
   input  pbp_pkg::size_type divisor,
   output logic              busy,
   output pbp_pkg::size_type quotient
);
   import pbp_pkg::*;

   logic                   run_ff, run_in;
   logic [DIV_COUNT_W-1:0] count_ff, count_in;
   size_type               rem_ff, rem_in;
   size_type               quo_ff, quo_in;
   size_type               div_ff, div_in;
   size_type               result_ff, result_in;
   logic [SIZE_W:0]        shifted;
   logic                   fits;

   always_comb begin
      shifted   = {rem_ff, quo_ff[SIZE_W-1]};
      fits      = shifted >= {1'b0, div_ff};
      run_in    = run_ff;
      count_in  = count_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      result_in = result_ff;
      if (start) begin
         run_in   = 1'b1;
         count_in = DIV_COUNT_W'(SIZE_W);
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
      end else if (run_ff) begin
         rem_in   = fits ? SIZE_W'(shifted - {1'b0, div_ff}) : shifted[SIZE_W-1:0];
         quo_in   = {quo_ff[SIZE_W-2:0], fits};
         count_in = count_ff - DIV_COUNT_W'(1);
         if (count_ff == DIV_COUNT_W'(1)) begin
            run_in    = 1'b0;
            // zero granule gives zero blocks
            result_in = (div_ff == '0) ? '0 : quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         count_ff  <= '0;
         result_ff <= SIZE_W'(1);
      end else begin
         run_ff    <= run_in;
         count_ff  <= count_in;
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy     = run_ff | start;
   assign quotient = result_ff;

endmodule

// File: rtl/pbp_datapath.sv
// ----------------------------------------------------------------------------
// pbp_datapath
// Registers, count store, multipliers, leftover tracking and result register.
// ----------------------------------------------------------------------------
module pbp_datapath #(
   parameter int MAX_PROCS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pbp_pkg::ctrl_cmd_type    cmd,
   output pbp_pkg::ctrl_status_type status,
   input  pbp_pkg::share_type       req_share,
   input  logic                     csr_valid,
   input  pbp_pkg::csr_addr_type    csr_index,
   input  pbp_pkg::csr_data_type    csr_data,
   output logic                     csr_ready,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output pbp_pkg::proc_index_type  rsp_proc_index,
   output pbp_pkg::elem_type        rsp_elem_count,
   output pbp_pkg::elem_type        rsp_offset,
   output logic                     rsp_last
);
   import pbp_pkg::*;

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W = $clog2(MAX_PROCS + 1);

   // configuration
   size_type   total_size_ff, total_size_in;
   size_type   granule_ff, granule_in;
   active_type active_procs_ff, active_procs_in;
   logic       div_start_ff, div_start_in;
   logic       div_busy;
   size_type   tblocks;

   // per-request pipeline
   share_type  share_ff;
   prod_type   product_ff;
   word_type   blocks_ff;

   // collection state
   logic [CNT_W-1:0] received_ff, received_in;
   left_type         leftover_ff, leftover_in;
   share_type        max_share_ff, max_share_in;
   share_type        min_share_ff, min_share_in;
   logic [IDX_W-1:0] max_index_ff, max_index_in;
   logic [IDX_W-1:0] min_index_ff, min_index_in;

   // burst
   word_type         store_mem [MAX_PROCS];
   word_type         rd_data_ff;
   word_type         adj_ff;
   logic [IDX_W-1:0] who_ff;
   logic [IDX_W-1:0] emit_k_ff, emit_k_in;
   word_type         offset_ff, offset_in;
   logic             rsp_valid_ff, rsp_valid_in;
   proc_index_type   rsp_index_ff;
   word_type         rsp_count_ff;
   word_type         rsp_offset_ff;
   logic             rsp_last_ff;

   logic [CNT_W-1:0] expected;
   logic [CNT_W-1:0] received_inc;
   logic [IDX_W-1:0] slot;
   left_type         left_base;
   word_type         emit_count;
   logic             emit_last;

   pbp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (total_size_ff),
      .divisor  (granule_ff),
      .busy     (div_busy),
      .quotient (tblocks)
   );

   // register writes
   always_comb begin
      total_size_in   = total_size_ff;
      granule_in      = granule_ff;
      active_procs_in = active_procs_ff;
      div_start_in    = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            CSR_TOTAL_SIZE: begin
               total_size_in = csr_data[SIZE_W-1:0];
               div_start_in  = 1'b1;
            end
            CSR_GRANULE: begin
               granule_in   = csr_data[SIZE_W-1:0];
               div_start_in = 1'b1;
            end
            CSR_ACTIVE_PROCS: begin
               active_procs_in = csr_data[ACTIVE_W-1:0];
            end
            default: begin
               div_start_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_size_ff   <= SIZE_W'(1);
         granule_ff      <= SIZE_W'(1);
         active_procs_ff <= ACTIVE_W'(1);
         div_start_ff    <= 1'b0;
      end else begin
         total_size_ff   <= total_size_in;
         granule_ff      <= granule_in;
         active_procs_ff <= active_procs_in;
         div_start_ff    <= div_start_in;
      end
   end

   assign csr_ready = 1'b1;

   // worker count, clamped to 1..MAX_PROCS
   always_comb begin
      if (active_procs_ff == '0) begin
         expected = CNT_W'(1);
      end else if (int'(active_procs_ff) > MAX_PROCS) begin
         expected = CNT_W'(MAX_PROCS);
      end else begin
         expected = CNT_W'(active_procs_ff);
      end
   end

   assign received_inc = received_ff + CNT_W'(1);
   assign slot         = received_ff[IDX_W-1:0];
   assign left_base    = (received_ff == '0) ? LEFT_W'(tblocks) : leftover_ff;

   // multiply, then round half up
   always_ff @(posedge clock) begin
      if (cmd.load_share) begin
         share_ff <= req_share;
      end
      if (cmd.mult) begin
         product_ff <= PROD_W'(tblocks) * PROD_W'(share_ff);
      end
      if (cmd.round) begin
         blocks_ff <= WORD_W'((product_ff + PROD_W'(ROUND_BIAS)) >> FRAC_W);
      end
   end

   always_comb begin
      received_in  = received_ff;
      leftover_in  = leftover_ff;
      max_share_in = max_share_ff;
      min_share_in = min_share_ff;
      max_index_in = max_index_ff;
      min_index_in = min_index_ff;
      if (cmd.clear) begin
         received_in  = '0;
         leftover_in  = '0;
         max_share_in = '0;
         min_share_in = '0;
         max_index_in = '0;
         min_index_in = '0;
      end else if (cmd.commit) begin
         received_in = received_inc;
         leftover_in = left_base - LEFT_W'(blocks_ff);
         if (received_ff == '0) begin
            max_share_in = share_ff;
            min_share_in = share_ff;
            max_index_in = '0;
            min_index_in = '0;
         end else begin
            if (share_ff > max_share_ff) begin
               max_share_in = share_ff;
               max_index_in = slot;
            end
            if (share_ff < min_share_ff) begin
               min_share_in = share_ff;
               min_index_in = slot;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         received_ff  <= '0;
         leftover_ff  <= '0;
         max_share_ff <= '0;
         min_share_ff <= '0;
         max_index_ff <= '0;
         min_index_ff <= '0;
      end else begin
         received_ff  <= received_in;
         leftover_ff  <= leftover_in;
         max_share_ff <= max_share_in;
         min_share_ff <= min_share_in;
         max_index_ff <= max_index_in;
         min_index_ff <= min_index_in;
      end
   end

   // count store
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         store_mem[slot] <= WORD_W'(blocks_ff * WORD_W'(granule_ff));
      end
      if (cmd.read) begin
         rd_data_ff <= store_mem[emit_k_ff];
      end
   end

   // leftover goes to the largest worker, a deficit comes off the smallest
   always_ff @(posedge clock) begin
      if (cmd.adjust) begin
         adj_ff <= (leftover_ff == '0) ? '0
                   : WORD_W'(leftover_ff[WORD_W-1:0] * WORD_W'(granule_ff));
         who_ff <= leftover_ff[LEFT_W-1] ? min_index_ff : max_index_ff;
      end
   end

   assign emit_count = rd_data_ff + ((emit_k_ff == who_ff) ? adj_ff : '0);
   assign emit_last  = (CNT_W'(emit_k_ff) + CNT_W'(1)) == received_ff;

   always_comb begin
      emit_k_in    = emit_k_ff;
      offset_in    = offset_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.adjust) begin
         emit_k_in = '0;
         offset_in = '0;
      end
      if (cmd.advance) begin
         emit_k_in = emit_k_ff + IDX_W'(1);
      end
      if (cmd.load) begin
         offset_in    = offset_ff + emit_count;
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_k_ff    <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         emit_k_ff    <= emit_k_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_index_ff  <= PROC_INDEX_W'(emit_k_ff);
         rsp_count_ff  <= emit_count;
         rsp_offset_ff <= offset_ff;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_proc_index = rsp_index_ff;
   assign rsp_elem_count = elem_type'(rsp_count_ff);
   assign rsp_offset     = elem_type'(rsp_offset_ff);
   assign rsp_last       = rsp_last_ff;

   assign status.div_busy  = div_busy;
   assign status.burst_due = received_inc >= expected;
   assign status.last_item = emit_last;
   assign status.rsp_taken = rsp_valid_ff & rsp_ready;

   a_no_request_while_dividing: assert property (@(posedge clock) disable iff (reset)
      cmd.load_share |-> !div_busy)
      else $error("request taken while quotient is stale");

   a_store_not_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> int'(received_ff) < MAX_PROCS)
      else $error("share written beyond the count store");

   a_cleared_after_burst: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (received_ff == '0 && leftover_ff == '0))
      else $error("collection state not cleared after burst");

   a_extremes_ordered: assert property (@(posedge clock) disable iff (reset)
      received_ff != '0 |-> min_share_ff <= max_share_ff)
      else $error("smallest share above largest share");

endmodule

// File: rtl/pbp_ctrl.sv
// ----------------------------------------------------------------------------
// pbp_ctrl
// Sequencer: per-request multiply/round/commit, then adjust and burst out.
// ----------------------------------------------------------------------------
module pbp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pbp_pkg::ctrl_status_type status,
   output pbp_pkg::ctrl_cmd_type    cmd
);
   import pbp_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.div_busy) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT:   state_in = ST_ROUND;
         ST_ROUND:  state_in = ST_COMMIT;
         ST_COMMIT: state_in = status.burst_due ? ST_ADJUST : ST_IDLE;
         ST_ADJUST: state_in = ST_READ;
         ST_READ:   state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_WAIT;
         ST_WAIT: begin
            if (status.rsp_taken) begin
               state_in = status.last_item ? ST_IDLE : ST_READ;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = !status.div_busy;
            cmd.load_share = req_valid && !status.div_busy;
         end
         ST_MULT:   cmd.mult   = 1'b1;
         ST_ROUND:  cmd.round  = 1'b1;
         ST_COMMIT: cmd.commit = 1'b1;
         ST_ADJUST: cmd.adjust = 1'b1;
         ST_READ:   cmd.read   = 1'b1;
         ST_LOAD:   cmd.load   = 1'b1;
         ST_WAIT: begin
            cmd.advance = status.rsp_taken && !status.last_item;
            cmd.clear   = status.rsp_taken && status.last_item;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/proportional_block_partitioner_core.sv
// ----------------------------------------------------------------------------
// proportional_block_partitioner_core
// Turns per-worker shares into whole-block element counts and offsets.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                  accepted when
//  req_bus   in         share                                    valid & ready
//  rsp_bus   out        proc_index, elem_count, offset, last     valid & ready
//  csr_bus   in         index, data                              valid & ready
//
//  a share goes through accept, multiply, round and commit to the count store
//  the final share adds an adjust step, then each result goes through a store read,
//  a load and the handshake
//  a total_size or granule write keeps req_ready low while dividing
//  after reset the quotient matches the reset registers and no divide runs
//  rsp stall holds the result; no request is taken until the burst has drained
module proportional_block_partitioner_core #(
   parameter int MAX_PROCS = 16
) (
   input logic   clock,
   input logic   reset,
   pbp_req_if.sink   req_bus,
   pbp_rsp_if.source rsp_bus,
   pbp_csr_if.sink   csr_bus
);
   import pbp_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   pbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pbp_datapath #(
      .MAX_PROCS (MAX_PROCS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_share      (req_bus.share),
      .csr_valid      (csr_bus.valid),
      .csr_index      (csr_bus.index),
      .csr_data       (csr_bus.data),
      .csr_ready      (csr_bus.ready),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_proc_index (rsp_bus.proc_index),
      .rsp_elem_count (rsp_bus.elem_count),
      .rsp_offset     (rsp_bus.offset),
      .rsp_last       (rsp_bus.last)
   );

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the proportional block partitioner. Shares go in
// with random gaps and the results are taken with random stalls. Each
// accepted share updates a bit-exact model of the block arithmetic kept in
// the bench. Each burst of assignments is checked field by field against
// the model, in order.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pbp_pkg::*;

   localparam int MAX_PROCS     = 16;
   localparam int SETTLE_CYCLES = 48;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 400;
   localparam share_type SHARE_ONE = share_type'(1 << FRAC_W);
   localparam csr_addr_type CSR_SPARE = 2'd3;
   localparam size_type SIZE_MAX  = '1;
   localparam share_type SHARE_MAX = '1;

   typedef struct {
      proc_index_type proc_index;
      elem_type       elem_count;
      elem_type       offset;
      logic           last;
   } assignment_type;

   typedef share_type share_set_type[$];

   logic clock = 1'b0;
   logic reset = 1'b1;

   int unsigned cycles_run      = 0;
   int unsigned error_count     = 0;
   int unsigned req_wait_max    = 8;
   int unsigned rsp_wait_max    = 8;
   int unsigned rsp_hold_cycles = 0;

   // partitioner state as the bench sees it
   size_type       cfg_total_size;
   size_type       cfg_granule;
   active_type     cfg_active_procs;
   word_type       count_store [MAX_PROCS];
   int unsigned    shares_held;
   left_type       block_balance;
   share_type      largest_share;
   share_type      smallest_share;
   proc_index_type largest_idx;
   proc_index_type smallest_idx;

   assignment_type assignments_due[$];

   pbp_req_if req_bus();
   pbp_rsp_if rsp_bus();
   pbp_csr_if csr_bus();

   proportional_block_partitioner_core #(
      .MAX_PROCS(MAX_PROCS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
   end

   initial begin
      wait (cycles_run >= CYCLE_LIMIT);
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic void restart_collection();
      foreach (count_store[i]) count_store[i] = '0;
      shares_held    = 0;
      block_balance  = '0;
      largest_share  = '0;
      smallest_share = '0;
      largest_idx    = '0;
      smallest_idx   = '0;
   endfunction

   function automatic int unsigned workers_wanted();
      if (cfg_active_procs == 0) return 1;
      if (cfg_active_procs > MAX_PROCS) return MAX_PROCS;
      return 32'(cfg_active_procs);
   endfunction

   // block count for one share; the final share of a collection queues the burst
   function automatic void partition_share(share_type share);
      logic [63:0]    total_blocks;
      logic [63:0]    blocks;
      word_type       adjust;
      word_type       run_offset;
      int unsigned    slot;
      int unsigned    burst_len;
      proc_index_type who;
      assignment_type a;

      total_blocks = (cfg_granule == 0) ? 64'd0 : 64'(cfg_total_size / cfg_granule);
      blocks = (total_blocks * 64'(share) + 64'(ROUND_BIAS)) >> FRAC_W;
      slot = shares_held % MAX_PROCS;
      if (shares_held == 0) begin
         largest_share  = share;
         smallest_share = share;
         largest_idx    = '0;
         smallest_idx   = '0;
         block_balance  = total_blocks[LEFT_W-1:0];
      end else begin
         if (share > largest_share) begin
            largest_share = share;
            largest_idx   = slot[PROC_INDEX_W-1:0];
         end
         if (share < smallest_share) begin
            smallest_share = share;
            smallest_idx   = slot[PROC_INDEX_W-1:0];
         end
      end
      count_store[slot] = word_type'(blocks * 64'(cfg_granule));
      block_balance = block_balance - blocks[LEFT_W-1:0];
      shares_held++;
      if (shares_held < workers_wanted()) return;

      burst_len = (shares_held > MAX_PROCS) ? MAX_PROCS : shares_held;
      if (block_balance != '0) begin
         // surplus to the largest worker, deficit from the smallest
         adjust = word_type'(64'(block_balance) * 64'(cfg_granule));
         who = block_balance[LEFT_W-1] ? smallest_idx : largest_idx;
         count_store[who] = count_store[who] + adjust;
      end
      run_offset = '0;
      for (int k = 0; k < burst_len; k++) begin
         a.proc_index = k[PROC_INDEX_W-1:0];
         a.elem_count = count_store[k];
         a.offset     = run_offset;
         a.last       = (k + 1 == burst_len);
         assignments_due.push_back(a);
         run_offset = run_offset + count_store[k];
      end
      restart_collection();
   endfunction

   function automatic void compare_field(string name, logic signed [32:0] want,
                                         logic signed [32:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   task automatic check_assignment();
      assignment_type want;
      if (assignments_due.size() == 0) begin
         $display("%0t: unexpected result: expected none, actual %0d %0d %0d %0b",
                  $time, rsp_bus.proc_index, rsp_bus.elem_count, rsp_bus.offset,
                  rsp_bus.last);
         error_count++;
         return;
      end
      want = assignments_due.pop_front();
      compare_field("proc_index", want.proc_index, rsp_bus.proc_index);
      compare_field("elem_count", want.elem_count, rsp_bus.elem_count);
      compare_field("offset", want.offset, rsp_bus.offset);
      compare_field("last", want.last, rsp_bus.last);
   endtask

   // all of these start and end on a falling edge
   task automatic send_share(share_type share);
      int unsigned gap;
      gap = $urandom_range(req_wait_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.share <= share;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      partition_share(share);
      @(negedge clock);
   endtask

   task automatic write_register(csr_addr_type idx, csr_data_type value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         CSR_TOTAL_SIZE:   cfg_total_size   = value[SIZE_W-1:0];
         CSR_GRANULE:      cfg_granule      = value[SIZE_W-1:0];
         CSR_ACTIVE_PROCS: cfg_active_procs = value[ACTIVE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (assignments_due.size() != 0) @(negedge clock);
      // a share that completes nothing may still be in flight, as may a divide
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic share_set_type well_formed_shares(int unsigned workers);
      share_set_type   shares;
      int unsigned     weight[$];
      longint unsigned total;
      bit              tied;
      tied  = ($urandom_range(3) == 0);
      total = 0;
      for (int i = 0; i < workers; i++) begin
         if ($urandom_range(7) == 0) weight.push_back(0);
         else if (tied) weight.push_back($urandom_range(3, 1) * 100);
         else weight.push_back($urandom_range(1000, 1));
         total += weight[i];
      end
      for (int i = 0; i < workers; i++) begin
         if (total == 0) shares.push_back('0);
         else shares.push_back(share_type'((64'(weight[i]) * 64'(SHARE_ONE)) / total));
      end
      return shares;
   endfunction

   function automatic share_set_type noise_shares(int unsigned count);
      share_set_type shares;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0:       shares.push_back('0);
            1:       shares.push_back(SHARE_ONE);
            2:       shares.push_back(SHARE_MAX);
            default: shares.push_back(share_type'($urandom_range(SHARE_MAX)));
         endcase
      end
      return shares;
   endfunction

   task automatic randomise_registers();
      size_type   total;
      size_type   block;
      active_type active;
      case ($urandom_range(4))
         0:       total = size_type'(1);
         1:       total = SIZE_MAX;
         2:       total = size_type'($urandom_range(1000, 1));
         3:       total = size_type'($urandom);
         default: total = size_type'($urandom_range(20000000, 1000));
      endcase
      case ($urandom_range(7))
         0:       block = size_type'(1);
         1:       block = '0;
         2:       block = SIZE_MAX;
         3:       block = size_type'($urandom);
         4, 5:    block = size_type'($urandom_range(16, 1));
         default: block = size_type'($urandom_range(4096, 1));
      endcase
      case ($urandom_range(5))
         0:       active = '0;
         1:       active = active_type'($urandom_range(31, 17));
         2:       active = active_type'(MAX_PROCS);
         default: active = active_type'($urandom_range(MAX_PROCS, 1));
      endcase
      // upper data bits are don't-care, so fill them with noise
      if ($urandom_range(3) != 0) write_register(CSR_TOTAL_SIZE, {1'($urandom), total});
      if ($urandom_range(3) != 0) write_register(CSR_GRANULE, {1'($urandom), block});
      if ($urandom_range(3) != 0) write_register(CSR_ACTIVE_PROCS, {27'($urandom), active});
      if ($urandom_range(7) == 0) write_register(CSR_SPARE, $urandom);
   endtask

   task automatic test_reset_values();
      send_share(SHARE_ONE);
      send_share('0);
      send_share(SHARE_MAX);
      wait_drained();
   endtask

   task automatic test_field_extremes();
      write_register(CSR_TOTAL_SIZE, csr_data_type'(SIZE_MAX));
      write_register(CSR_GRANULE, 1);
      write_register(CSR_ACTIVE_PROCS, 2);
      send_share(SHARE_ONE);
      send_share('0);
      // counts wrap past 32 bits and the deficit is huge
      send_share(SHARE_MAX);
      send_share(SHARE_MAX);
      wait_drained();
   endtask

   task automatic test_ties_and_leftover();
      write_register(CSR_TOTAL_SIZE, 15);
      write_register(CSR_GRANULE, 5);
      write_register(CSR_ACTIVE_PROCS, 4);
      // halves round up, deficit taken from the first zero share
      send_share('0);
      send_share(SHARE_ONE / 2);
      send_share(SHARE_ONE / 2);
      send_share('0);
      wait_drained();
      write_register(CSR_TOTAL_SIZE, 10);
      // all tied, surplus goes to worker zero
      repeat (4) send_share(17'd6553);
      wait_drained();
   endtask

   task automatic test_zero_granule();
      write_register(CSR_TOTAL_SIZE, 1000);
      write_register(CSR_GRANULE, 0);
      write_register(CSR_ACTIVE_PROCS, 2);
      send_share(SHARE_ONE / 2);
      send_share(SHARE_ONE / 2);
      wait_drained();
   endtask

   task automatic test_active_out_of_range();
      write_register(CSR_TOTAL_SIZE, 77);
      write_register(CSR_GRANULE, 2);
      write_register(CSR_ACTIVE_PROCS, 0);
      send_share(17'd40000);
      wait_drained();
   endtask

   task automatic test_mid_collection_change();
      write_register(CSR_TOTAL_SIZE, 100);
      write_register(CSR_GRANULE, 3);
      write_register(CSR_ACTIVE_PROCS, 4);
      send_share(17'd20000);
      send_share(17'd20000);
      wait_drained();
      write_register(CSR_GRANULE, 7);
      write_register(CSR_SPARE, 32'hFFFF_FFFF);
      send_share(17'd20000);
      wait_drained();
      // already holding three, so the next share closes the collection
      write_register(CSR_ACTIVE_PROCS, 2);
      send_share(17'd5536);
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      share_set_type shares;
      write_register(CSR_TOTAL_SIZE, 1000000);
      write_register(CSR_GRANULE, 4);
      write_register(CSR_ACTIVE_PROCS, 8);
      req_wait_max    = 0;
      rsp_wait_max    = 2;
      rsp_hold_cycles = 200;
      repeat (3) begin
         shares = well_formed_shares(8);
         foreach (shares[i]) send_share(shares[i]);
      end
      wait_drained();
      req_wait_max = 8;
      rsp_wait_max = 8;
   endtask

   task automatic test_random_partitions();
      int unsigned   sent;
      int unsigned   workers;
      share_set_type shares;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         randomise_registers();
         workers = workers_wanted();
         req_wait_max = ($urandom_range(3) == 0) ? 0 : 8;
         rsp_wait_max = ($urandom_range(3) == 0) ? 0 : 8;
         repeat ($urandom_range(3, 1)) begin
            if ($urandom_range(4) == 0) shares = noise_shares(workers);
            else shares = well_formed_shares(workers);
            foreach (shares[i]) send_share(shares[i]);
            sent += workers;
         end
         // sometimes leave a collection open across the next register change
         if (workers > 1 && $urandom_range(7) == 0) begin
            shares = noise_shares($urandom_range(workers - 1, 1));
            foreach (shares[i]) send_share(shares[i]);
            sent += shares.size();
         end
         wait_drained();
      end
   endtask

   // result side: random stalls, plus one long hold when requested
   initial begin : result_sink
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = $urandom_range(rsp_wait_max);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         check_assignment();
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.share = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_TOTAL_SIZE;
      csr_bus.data  = '0;
      cfg_total_size   = 1;
      cfg_granule      = 1;
      cfg_active_procs = 1;
      restart_collection();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_values();
      test_field_extremes();
      test_ties_and_leftover();
      test_zero_granule();
      test_active_out_of_range();
      test_mid_collection_change();
      test_output_backpressure();
      test_random_partitions();

      wait_drained();
      if (error_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/pbp_pkg.sv
rtl/pbp_if.sv
rtl/pbp_divider.sv
rtl/pbp_datapath.sv
rtl/pbp_ctrl.sv
rtl/proportional_block_partitioner_core.sv
bench/tb_top.sv
